FILE: hw/rtl/mrm_pkg.sv
package mrm_pkg;

    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_WIDTH = 2 * ELEM_WIDTH;
    localparam int PAIR_WIDTH = PROD_WIDTH + 1;
    localparam int ACC_WIDTH  = PROD_WIDTH + 2;
    localparam int DIM        = 4;
    localparam int ROW_BITS   = $clog2(DIM);

    localparam logic [ELEM_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic [ELEM_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
    localparam logic [ELEM_WIDTH-1:0] ELEM_ONE =
        (FRAC_BITS >= ELEM_WIDTH - 1) ? ELEM_MAX : ELEM_WIDTH'(64'd1 << FRAC_BITS);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MUL  = 1'b1;

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic signed [PAIR_WIDTH-1:0] pair_t;
    typedef logic signed [ACC_WIDTH-1:0]  acc_t;
    typedef elem_t [DIM-1:0]              elem_vec_t;

    typedef struct packed {
        logic                opcode;
        logic [ROW_BITS-1:0] row_index;
        elem_t               elem0;
        elem_t               elem1;
        elem_t               elem2;
        elem_t               elem3;
    } row_req_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] result_row;
        elem_t               prod0;
        elem_t               prod1;
        elem_t               prod2;
        elem_t               prod3;
        logic                saturated;
    } prod_rsp_t;

    // stage advance enables: products, pair sums, full sum, output
    typedef struct packed {
        logic mul;
        logic pair;
        logic sum;
        logic fin;
    } adv_t;

endpackage

FILE: hw/rtl/mrm_in_if.sv
interface mrm_in_if;
    logic               valid;
    logic               ready;
    mrm_pkg::row_req_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/mrm_out_if.sv
interface mrm_out_if;
    logic               valid;
    logic               ready;
    mrm_pkg::prod_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/mrm_column.sv
module mrm_column (
    input  logic                clk,
    input  mrm_pkg::adv_t       adv,
    input  mrm_pkg::elem_vec_t  a,
    input  mrm_pkg::elem_vec_t  b,
    output mrm_pkg::elem_t      prod,
    output logic                clip
);

    mrm_pkg::prod_t prod_reg [mrm_pkg::DIM];
    mrm_pkg::pair_t pair_reg [2];
    mrm_pkg::acc_t  sum_reg;
    mrm_pkg::elem_t res_reg;
    logic           clip_reg;

    mrm_pkg::acc_t  shifted;
    logic           in_range;
    mrm_pkg::elem_t res_next;

    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            for (int k = 0; k < mrm_pkg::DIM; k++)
            begin
                prod_reg[k] <= mrm_pkg::prod_t'(a[k]) * mrm_pkg::prod_t'(b[k]);
            end
        end
        if (adv.pair)
        begin
            pair_reg[0] <= mrm_pkg::pair_t'(prod_reg[0]) + mrm_pkg::pair_t'(prod_reg[1]);
            pair_reg[1] <= mrm_pkg::pair_t'(prod_reg[2]) + mrm_pkg::pair_t'(prod_reg[3]);
        end
        if (adv.sum)
        begin
            sum_reg <= mrm_pkg::acc_t'(pair_reg[0]) + mrm_pkg::acc_t'(pair_reg[1]);
        end
        if (adv.fin)
        begin
            res_reg  <= res_next;
            clip_reg <= !in_range;
        end
    end

    // floor shift, then clip to element range
    always_comb
    begin
        shifted  = sum_reg >>> mrm_pkg::FRAC_BITS;
        in_range = (&shifted[mrm_pkg::ACC_WIDTH-1:mrm_pkg::ELEM_WIDTH-1])
                || !(|shifted[mrm_pkg::ACC_WIDTH-1:mrm_pkg::ELEM_WIDTH-1]);
        if (in_range)
            res_next = shifted[mrm_pkg::ELEM_WIDTH-1:0];
        else if (shifted[mrm_pkg::ACC_WIDTH-1])
            res_next = mrm_pkg::ELEM_MIN;
        else
            res_next = mrm_pkg::ELEM_MAX;
    end

    assign prod = res_reg;
    assign clip = clip_reg;

endmodule

FILE: hw/rtl/matrix4x4_row_multiply.sv
// Channel   Role   Payload
// row_ch    sink   opcode, row_index, elem0..elem3 (load or multiply request)
// prod_ch   source result_row, prod0..prod3, saturated (one per multiply)
//
// One request per cycle while ready is high; a multiply result passes through
// five register stages: input, 16 multipliers, pair adds, final add, shift/saturate.
// A load writes the stored row at acceptance and produces no result.
// Reset sets the stored matrix to identity and empties the pipeline.
// Stalls back up stage by stage; ready falls only when every stage holds a
// multiply and prod_ch is stalled.
module matrix4x4_row_multiply (
    input  logic      clk,
    input  logic      rst_n,
    mrm_in_if.sink    row_ch,
    mrm_out_if.source prod_ch
);

    mrm_pkg::elem_t                mat_reg [mrm_pkg::DIM][mrm_pkg::DIM];
    mrm_pkg::elem_vec_t            a_reg;
    logic [mrm_pkg::ROW_BITS-1:0]  row_reg [5];
    logic                          v_reg   [5];
    logic                          en_in;
    mrm_pkg::adv_t                 adv;
    logic                          fire;
    mrm_pkg::elem_vec_t            elems;
    mrm_pkg::elem_vec_t            bcol [mrm_pkg::DIM];
    mrm_pkg::elem_t                res  [mrm_pkg::DIM];
    logic [mrm_pkg::DIM-1:0]       clips;

    assign adv.fin  = !v_reg[4] || prod_ch.ready;
    assign adv.sum  = !v_reg[3] || adv.fin;
    assign adv.pair = !v_reg[2] || adv.sum;
    assign adv.mul  = !v_reg[1] || adv.pair;
    assign en_in    = !v_reg[0] || adv.mul;

    assign row_ch.ready = en_in;
    assign fire         = row_ch.valid && en_in;

    assign elems[0] = row_ch.payload.elem0;
    assign elems[1] = row_ch.payload.elem1;
    assign elems[2] = row_ch.payload.elem2;
    assign elems[3] = row_ch.payload.elem3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < mrm_pkg::DIM; r++)
            begin
                for (int c = 0; c < mrm_pkg::DIM; c++)
                begin
                    mat_reg[r][c] <= (r == c) ? mrm_pkg::ELEM_ONE : '0;
                end
            end
        end
        else if (fire && row_ch.payload.opcode == mrm_pkg::OP_LOAD)
        begin
            for (int c = 0; c < mrm_pkg::DIM; c++)
            begin
                mat_reg[row_ch.payload.row_index][c] <= elems[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 5; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            if (en_in)
                v_reg[0] <= fire && row_ch.payload.opcode == mrm_pkg::OP_MUL;
            if (adv.mul)
                v_reg[1] <= v_reg[0];
            if (adv.pair)
                v_reg[2] <= v_reg[1];
            if (adv.sum)
                v_reg[3] <= v_reg[2];
            if (adv.fin)
                v_reg[4] <= v_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_in)
        begin
            a_reg      <= elems;
            row_reg[0] <= row_ch.payload.row_index;
        end
        if (adv.mul)
            row_reg[1] <= row_reg[0];
        if (adv.pair)
            row_reg[2] <= row_reg[1];
        if (adv.sum)
            row_reg[3] <= row_reg[2];
        if (adv.fin)
            row_reg[4] <= row_reg[3];
    end

    // products register when the input stage moves on
    always_comb
    begin
        for (int c = 0; c < mrm_pkg::DIM; c++)
        begin
            for (int k = 0; k < mrm_pkg::DIM; k++)
            begin
                bcol[c][k] = mat_reg[k][c];
            end
        end
    end

    for (genvar c = 0; c < mrm_pkg::DIM; c++)
    begin : g_col
        mrm_column u_col (
            .clk  (clk),
            .adv  (adv),
            .a    (a_reg),
            .b    (bcol[c]),
            .prod (res[c]),
            .clip (clips[c])
        );
    end

    assign prod_ch.valid              = v_reg[4];
    assign prod_ch.payload.result_row = row_reg[4];
    assign prod_ch.payload.prod0      = res[0];
    assign prod_ch.payload.prod1      = res[1];
    assign prod_ch.payload.prod2      = res[2];
    assign prod_ch.payload.prod3      = res[3];
    assign prod_ch.payload.saturated  = |clips;

endmodule

FILE: tb/sv/matrix4x4_row_multiply_test.sv
module matrix4x4_row_multiply_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASE_REQUESTS = 517;

    logic clk = 1'b0;
    logic rst_n;

    mrm_in_if  row_ch ();
    mrm_out_if prod_ch ();

    matrix4x4_row_multiply i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .row_ch  (row_ch),
        .prod_ch (prod_ch)
    );

    always #5 clk = ~clk;

    mrm_pkg::elem_t     right_rows [mrm_pkg::DIM][mrm_pkg::DIM];
    mrm_pkg::prod_rsp_t pending_products [$];
    mrm_pkg::row_req_t  script_req [$];
    bit                 script_typed [$];
    mrm_pkg::prod_rsp_t script_want [$];
    int                 send_idle_pct = 15;
    int                 recv_idle_pct = 66;
    int                 errors = 0;
    int unsigned        cycle_count = 0;

    function automatic mrm_pkg::row_req_t req_of(input logic op, input int row,
                                                 input mrm_pkg::elem_t e0,
                                                 input mrm_pkg::elem_t e1,
                                                 input mrm_pkg::elem_t e2,
                                                 input mrm_pkg::elem_t e3);
        mrm_pkg::row_req_t req;
        req.opcode    = op;
        req.row_index = mrm_pkg::ROW_BITS'(row);
        req.elem0     = e0;
        req.elem1     = e1;
        req.elem2     = e2;
        req.elem3     = e3;
        return req;
    endfunction

    function automatic mrm_pkg::prod_rsp_t rsp_of(input int row, input mrm_pkg::elem_t p0,
                                                  input mrm_pkg::elem_t p1,
                                                  input mrm_pkg::elem_t p2,
                                                  input mrm_pkg::elem_t p3,
                                                  input logic sat);
        mrm_pkg::prod_rsp_t rsp;
        rsp.result_row = mrm_pkg::ROW_BITS'(row);
        rsp.prod0      = p0;
        rsp.prod1      = p1;
        rsp.prod2      = p2;
        rsp.prod3      = p3;
        rsp.saturated  = sat;
        return rsp;
    endfunction

    task automatic add_step(input mrm_pkg::row_req_t req, input bit typed,
                            input mrm_pkg::prod_rsp_t want);
        script_req.push_back(req);
        script_typed.push_back(typed);
        script_want.push_back(want);
    endtask

    // left row times stored matrix, floor shift, clip to element range
    function automatic mrm_pkg::prod_rsp_t row_product(input mrm_pkg::row_req_t req);
        mrm_pkg::prod_rsp_t rsp;
        mrm_pkg::elem_t     lhs [mrm_pkg::DIM];
        mrm_pkg::elem_t     col_val [mrm_pkg::DIM];
        logic signed [95:0] acc;
        logic signed [95:0] wide_a;
        logic signed [95:0] wide_b;
        logic signed [95:0] scaled;
        logic signed [95:0] hi_lim;
        logic signed [95:0] lo_lim;
        logic               clip;
        lhs[0] = req.elem0;
        lhs[1] = req.elem1;
        lhs[2] = req.elem2;
        lhs[3] = req.elem3;
        hi_lim = mrm_pkg::ELEM_MAX;
        lo_lim = mrm_pkg::elem_t'(mrm_pkg::ELEM_MIN);
        clip   = 1'b0;
        for (int j = 0; j < mrm_pkg::DIM; j++)
        begin
            acc = '0;
            for (int k = 0; k < mrm_pkg::DIM; k++)
            begin
                wide_a = lhs[k];
                wide_b = right_rows[k][j];
                acc    = acc + wide_a * wide_b;
            end
            scaled = acc >>> mrm_pkg::FRAC_BITS;
            if (scaled > hi_lim)
            begin
                col_val[j] = mrm_pkg::ELEM_MAX;
                clip       = 1'b1;
            end
            else if (scaled < lo_lim)
            begin
                col_val[j] = mrm_pkg::ELEM_MIN;
                clip       = 1'b1;
            end
            else
            begin
                col_val[j] = scaled[mrm_pkg::ELEM_WIDTH-1:0];
            end
        end
        rsp.result_row = req.row_index;
        rsp.prod0      = col_val[0];
        rsp.prod1      = col_val[1];
        rsp.prod2      = col_val[2];
        rsp.prod3      = col_val[3];
        rsp.saturated  = clip;
        return rsp;
    endfunction

    function automatic mrm_pkg::elem_t pick_elem();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 7))
            0: return mrm_pkg::ELEM_MAX;
            1: return mrm_pkg::ELEM_MIN;
            2: return '0;
            3: return raw[0] ? mrm_pkg::ELEM_ONE : -mrm_pkg::ELEM_ONE;
            4: return raw;
            default: return mrm_pkg::elem_t'($signed(raw[19:0]));
        endcase
    endfunction

    function automatic mrm_pkg::row_req_t random_request();
        mrm_pkg::row_req_t req;
        req.opcode    = ($urandom_range(0, 99) < 15) ? mrm_pkg::OP_LOAD : mrm_pkg::OP_MUL;
        req.row_index = mrm_pkg::ROW_BITS'($urandom_range(0, mrm_pkg::DIM - 1));
        req.elem0     = pick_elem();
        req.elem1     = pick_elem();
        req.elem2     = pick_elem();
        req.elem3     = pick_elem();
        if (req.opcode == mrm_pkg::OP_LOAD && $urandom_range(0, 3) == 0)
        begin
            req.elem0 = (req.row_index == 0) ? mrm_pkg::ELEM_ONE : '0;
            req.elem1 = (req.row_index == 1) ? mrm_pkg::ELEM_ONE : '0;
            req.elem2 = (req.row_index == 2) ? mrm_pkg::ELEM_ONE : '0;
            req.elem3 = (req.row_index == 3) ? mrm_pkg::ELEM_ONE : '0;
        end
        return req;
    endfunction

    task automatic send_request(input mrm_pkg::row_req_t req, input bit typed,
                                input mrm_pkg::prod_rsp_t want);
        bit accepted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            row_ch.valid <= 1'b0;
            @(posedge clk);
        end
        row_ch.valid   <= 1'b1;
        row_ch.payload <= req;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = row_ch.ready;
            @(posedge clk);
        end
        if (req.opcode == mrm_pkg::OP_LOAD)
        begin
            right_rows[req.row_index][0] = req.elem0;
            right_rows[req.row_index][1] = req.elem1;
            right_rows[req.row_index][2] = req.elem2;
            right_rows[req.row_index][3] = req.elem3;
        end
        else
        begin
            pending_products.push_back(typed ? want : row_product(req));
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        prod_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(negedge clk)
    begin : product_check
        mrm_pkg::prod_rsp_t got;
        mrm_pkg::prod_rsp_t want;
        if (rst_n && prod_ch.valid && prod_ch.ready)
        begin
            got = prod_ch.payload;
            if (pending_products.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected product, expected none, got %h", $time, got);
            end
            else
            begin
                want = pending_products.pop_front();
                check_field("result_row", want.result_row, got.result_row);
                check_field("prod0", want.prod0, got.prod0);
                check_field("prod1", want.prod1, got.prod1);
                check_field("prod2", want.prod2, got.prod2);
                check_field("prod3", want.prod3, got.prod3);
                check_field("saturated", want.saturated, got.saturated);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        row_ch.valid   = 1'b0;
        row_ch.payload = '0;
        for (int r = 0; r < mrm_pkg::DIM; r++)
        begin
            for (int c = 0; c < mrm_pkg::DIM; c++)
            begin
                right_rows[r][c] = (r == c) ? mrm_pkg::ELEM_ONE : '0;
            end
        end

        // identity after reset passes the row through
        add_step(req_of(mrm_pkg::OP_MUL, 2, mrm_pkg::ELEM_ONE, -1, mrm_pkg::ELEM_MAX,
                        mrm_pkg::ELEM_MIN), 1,
                 rsp_of(2, mrm_pkg::ELEM_ONE, -1, mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MIN, 1'b0));
        add_step(req_of(mrm_pkg::OP_MUL, 1, 32'h1234_5678, 32'hFF54_3211, 32'h0003_8000,
                        32'h8000_0001), 0, '0);
        for (int r = 0; r < mrm_pkg::DIM; r++)
        begin
            add_step(req_of(mrm_pkg::OP_LOAD, r, mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MAX,
                            mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MAX), 0, '0);
        end
        add_step(req_of(mrm_pkg::OP_MUL, 0, mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MAX,
                        mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MAX), 1,
                 rsp_of(0, mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MAX,
                        mrm_pkg::ELEM_MAX, 1'b1));
        add_step(req_of(mrm_pkg::OP_MUL, 1, mrm_pkg::ELEM_MIN, mrm_pkg::ELEM_MIN,
                        mrm_pkg::ELEM_MIN, mrm_pkg::ELEM_MIN), 1,
                 rsp_of(1, mrm_pkg::ELEM_MIN, mrm_pkg::ELEM_MIN, mrm_pkg::ELEM_MIN,
                        mrm_pkg::ELEM_MIN, 1'b1));
        add_step(req_of(mrm_pkg::OP_MUL, 2, mrm_pkg::ELEM_ONE, 0, 0, 0), 1,
                 rsp_of(2, mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MAX,
                        mrm_pkg::ELEM_MAX, 1'b0));
        for (int r = 0; r < mrm_pkg::DIM; r++)
        begin
            add_step(req_of(mrm_pkg::OP_LOAD, r, mrm_pkg::ELEM_MIN, mrm_pkg::ELEM_MIN,
                            mrm_pkg::ELEM_MIN, mrm_pkg::ELEM_MIN), 0, '0);
        end
        add_step(req_of(mrm_pkg::OP_MUL, 3, mrm_pkg::ELEM_MIN, mrm_pkg::ELEM_MIN,
                        mrm_pkg::ELEM_MIN, mrm_pkg::ELEM_MIN), 1,
                 rsp_of(3, mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MAX,
                        mrm_pkg::ELEM_MAX, 1'b1));
        // one step past the top of the range
        add_step(req_of(mrm_pkg::OP_MUL, 0, -mrm_pkg::ELEM_ONE, 0, 0, 0), 1,
                 rsp_of(0, mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MAX,
                        mrm_pkg::ELEM_MAX, 1'b1));
        add_step(req_of(mrm_pkg::OP_LOAD, 0, 1, 0, 0, 0), 0, '0);
        for (int r = 1; r < mrm_pkg::DIM; r++)
        begin
            add_step(req_of(mrm_pkg::OP_LOAD, r, 0, 0, 0, 0), 0, '0);
        end
        // floor toward minus infinity
        add_step(req_of(mrm_pkg::OP_MUL, 1, -1, 0, 0, 0), 1, rsp_of(1, -1, 0, 0, 0, 1'b0));
        add_step(req_of(mrm_pkg::OP_MUL, 2, 1, 0, 0, 0), 1, rsp_of(2, 0, 0, 0, 0, 1'b0));
        add_step(req_of(mrm_pkg::OP_MUL, 3, mrm_pkg::ELEM_MAX, mrm_pkg::ELEM_MIN, 7, -7),
                 0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < script_req.size(); i++)
        begin
            send_request(script_req[i], script_typed[i], script_want[i]);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 66 : 0;
            recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 15 : 0;
            repeat (PHASE_REQUESTS) send_request(random_request(), 1'b0, '0);
        end
        row_ch.valid <= 1'b0;

        wait (pending_products.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_products.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
